[design/psvd_pkg.sv]
// Package of shared types and codes for the protobuf scalar value decoder.
`default_nettype none

package psvd_pkg;

  // Type selector codes carried in the func field
  typedef enum logic [3:0] {
    FUNC_INT32   = 4'd0,
    FUNC_INT64   = 4'd1,
    FUNC_UINT32  = 4'd2,
    FUNC_UINT64  = 4'd3,
    FUNC_SINT32  = 4'd4,
    FUNC_SINT64  = 4'd5,
    FUNC_BOOL    = 4'd6,
    FUNC_ENUM    = 4'd7,
    FUNC_FIXED32 = 4'd8,
    FUNC_FIXED64 = 4'd9,
    FUNC_FLOAT   = 4'd10,
    FUNC_DOUBLE  = 4'd11
  } func_e;

  // Last byte index at which a varint may still carry payload
  localparam logic [3:0] VarintLastIdx = 4'd9;

  // One wire byte with its type selector
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] func;
  } in_req_t;

  // One decoded scalar value
  typedef struct packed {
    logic [63:0] value;
    logic        overflow;
  } out_res_t;

endpackage

`default_nettype wire

[design/protobuf_scalar_value_decoder.sv]
// Top level of the byte-serial protobuf scalar value decoder.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o    | in_req_i  (data_byte, func)
//  out     | output    | out_valid_o / out_ready_i  | out_res_o (value, overflow)
//
// One wire byte is taken per cycle; the byte assembly and finishing logic sits
// between the decode state registers and the result register.
// A value's result is registered and shown in the cycle after its last byte is taken.
// Reset (rst_ni low) returns the decoder to idle with no result pending.
// A result held in the output register and not taken stalls the input side.
`default_nettype none

module protobuf_scalar_value_decoder (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  psvd_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output psvd_pkg::out_res_t  out_res_o
);

  logic               in_fire;
  logic               res_valid;
  psvd_pkg::out_res_t res;

  // Accept while the result register is free or being emptied
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  psvd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_req_i    (in_req_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  psvd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire && res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

[design/psvd_core.sv]
// Decode state and per-byte assembly logic of the scalar value decoder.
`default_nettype none

module psvd_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_fire_i,
  input  psvd_pkg::in_req_t   in_req_i,
  output logic                res_valid_o,
  output psvd_pkg::out_res_t  res_o
);

  logic [63:0] acc_q, acc_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  kind_q, kind_d;

  logic        first;
  logic [3:0]  kind;
  logic [63:0] acc_base;
  logic [63:0] acc_var;
  logic [63:0] acc_fix;
  logic [5:0]  var_sh;
  logic [2:0]  fix_idx;
  logic [3:0]  fix_len;
  logic        is_varint;
  logic        is_fixed;
  logic [31:0] zz32;
  logic [63:0] var_val;
  logic [7:0]  b;

  assign b        = in_req_i.data_byte;
  assign first    = (idx_q == 4'd0);
  assign kind     = first ? in_req_i.func : kind_q;
  assign acc_base = first ? 64'd0 : acc_q;

  assign is_varint = (kind <= psvd_pkg::FUNC_SINT64) || (kind == psvd_pkg::FUNC_ENUM);
  assign is_fixed  = (kind >= psvd_pkg::FUNC_FIXED32) && (kind <= psvd_pkg::FUNC_DOUBLE);

  // Place the 7-bit group, or bit 0 alone in bit 63 on the last byte
  assign var_sh = {idx_q[2:0], 3'b000} - {3'b000, idx_q[2:0]} + (idx_q[3] ? 6'd56 : 6'd0);
  always_comb begin
    if (idx_q < psvd_pkg::VarintLastIdx) begin
      acc_var = acc_base | ({57'd0, b[6:0]} << var_sh);
    end else begin
      acc_var = acc_base | {b[0], 63'd0};
    end
  end

  // Place a fixed byte, clamping the index to the value length
  assign fix_len = ((kind == psvd_pkg::FUNC_FIXED32) || (kind == psvd_pkg::FUNC_FLOAT))
                   ? 4'd4 : 4'd8;
  assign fix_idx = (idx_q >= fix_len) ? 3'(fix_len - 4'd1) : idx_q[2:0];
  assign acc_fix = acc_base | ({56'd0, b} << {fix_idx, 3'b000});

  // Finish a varint by kind
  assign zz32 = {1'b0, acc_var[31:1]} ^ {32{acc_var[0]}};
  always_comb begin
    unique case (kind)
      psvd_pkg::FUNC_INT32, psvd_pkg::FUNC_ENUM: var_val = {{32{acc_var[31]}}, acc_var[31:0]};
      psvd_pkg::FUNC_UINT32: var_val = {32'd0, acc_var[31:0]};
      psvd_pkg::FUNC_SINT32: var_val = {{32{zz32[31]}}, zz32};
      psvd_pkg::FUNC_SINT64: var_val = {1'b0, acc_var[63:1]} ^ {64{acc_var[0]}};
      default:               var_val = acc_var;
    endcase
  end

  // Next state and result for the byte on offer
  always_comb begin
    acc_d       = acc_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (first && (in_req_i.func > psvd_pkg::FUNC_DOUBLE)) begin
      // drop: unknown selector on a first byte
    end else begin
      kind_d = kind;
      if (is_varint) begin
        if (b[7] && (idx_q < psvd_pkg::VarintLastIdx)) begin
          acc_d = acc_var;
          idx_d = idx_q + 4'd1;
        end else begin
          acc_d          = 64'd0;
          idx_d          = 4'd0;
          res_valid_o    = 1'b1;
          res_o.overflow = b[7];
          res_o.value    = b[7] ? 64'd0 : var_val;
        end
      end else if (is_fixed) begin
        if ({1'b0, fix_idx} + 4'd1 < fix_len) begin
          acc_d = acc_fix;
          idx_d = {1'b0, fix_idx} + 4'd1;
        end else begin
          acc_d       = 64'd0;
          idx_d       = 4'd0;
          res_valid_o = 1'b1;
          res_o.value = (kind == psvd_pkg::FUNC_FIXED32)
                        ? {{32{acc_fix[31]}}, acc_fix[31:0]} : acc_fix;
        end
      end else begin
        // bool: one byte, any nonzero gives one
        acc_d       = 64'd0;
        idx_d       = 4'd0;
        res_valid_o = 1'b1;
        res_o.value = {63'd0, (b != 8'd0)};
      end
    end
  end

  // Hold decode state, advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 64'd0;
      idx_q  <= 4'd0;
      kind_q <= 4'd0;
    end else if (in_fire_i) begin
      acc_q  <= acc_d;
      idx_q  <= idx_d;
      kind_q <= kind_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= psvd_pkg::VarintLastIdx)
    else $error("byte index beyond last varint byte");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && res_valid_o) |=> (idx_q == 4'd0))
    else $error("decoder not idle after a result");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.overflow) |-> (res_o.value == 64'd0))
    else $error("overflow result carries a nonzero value");

  a_fixed32_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((idx_q != 4'd0) && ((kind_q == psvd_pkg::FUNC_FIXED32) ||
     (kind_q == psvd_pkg::FUNC_FLOAT))) |-> (idx_q < 4'd4))
    else $error("32-bit fixed value ran past four bytes");
`endif

endmodule

`default_nettype wire

[design/psvd_out_buf.sv]
// Result register with valid/ready handshake for the scalar value decoder.
`default_nettype none

module psvd_out_buf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  psvd_pkg::out_res_t  res_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output psvd_pkg::out_res_t  out_res_o
);

  logic               valid_q, valid_d;
  psvd_pkg::out_res_t res_q;

  // Load a new result, drop the held one once taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for the byte-serial protobuf scalar value decoder.
`timescale 1ns / 100ps

module tb;

  localparam int          RandomBytes = 1350;
  localparam int          HoldCycles  = 300;
  localparam logic [3:0]  FuncUnknown = 4'hF;

  // Predict decoded values from accepted wire bytes and check results in order
  class decode_scoreboard;
    logic [63:0]        acc;
    logic [3:0]         idx;
    psvd_pkg::func_e    kind;
    psvd_pkg::out_res_t expected_q[$];
    int                 mismatches;

    function new();
      acc        = '0;
      idx        = '0;
      kind       = psvd_pkg::FUNC_INT32;
      mismatches = 0;
    endfunction

    function automatic logic [63:0] sext32(logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
    endfunction

    // Advance the decode state by one byte; return 0 when the byte is dropped
    function automatic bit note_request(psvd_pkg::in_req_t r);
      logic [7:0]         b;
      logic [31:0]        w;
      int unsigned        len;
      bit                 done;
      psvd_pkg::out_res_t res;
      b            = r.data_byte;
      done         = 1'b0;
      res.value    = '0;
      res.overflow = 1'b0;
      if (idx == 0) begin
        // an unknown selector on a first byte is ignored
        if (r.func > psvd_pkg::FUNC_DOUBLE) return 1'b0;
        kind = psvd_pkg::func_e'(r.func);
        acc  = '0;
      end
      case (kind)
        psvd_pkg::FUNC_BOOL: begin
          res.value = {63'd0, b != 8'd0};
          done      = 1'b1;
        end
        psvd_pkg::FUNC_FIXED32, psvd_pkg::FUNC_FLOAT,
        psvd_pkg::FUNC_FIXED64, psvd_pkg::FUNC_DOUBLE: begin
          len = (kind == psvd_pkg::FUNC_FIXED32 || kind == psvd_pkg::FUNC_FLOAT) ? 4 : 8;
          acc = acc | (64'(b) << (8 * idx));
          if (idx + 1 < len) begin
            idx++;
          end else begin
            res.value = (kind == psvd_pkg::FUNC_FIXED32) ? sext32(acc) : acc;
            done      = 1'b1;
          end
        end
        default: begin
          // varint: the tenth byte only feeds bit 63
          if (idx < psvd_pkg::VarintLastIdx) acc = acc | (64'(b[6:0]) << (7 * idx));
          else acc[63] = acc[63] | b[0];
          if (!b[7]) begin
            done = 1'b1;
            case (kind)
              psvd_pkg::FUNC_INT32, psvd_pkg::FUNC_ENUM: res.value = sext32(acc);
              psvd_pkg::FUNC_UINT32: res.value = {32'd0, acc[31:0]};
              psvd_pkg::FUNC_SINT32: begin
                w         = acc[31:0];
                w         = (w >> 1) ^ {32{w[0]}};
                res.value = sext32({32'd0, w});
              end
              psvd_pkg::FUNC_SINT64: res.value = (acc >> 1) ^ {64{acc[0]}};
              default:               res.value = acc;
            endcase
          end else if (idx >= psvd_pkg::VarintLastIdx) begin
            res.overflow = 1'b1;
            done         = 1'b1;
          end else begin
            idx++;
          end
        end
      endcase
      if (done) begin
        expected_q.push_back(res);
        idx = '0;
        acc = '0;
      end
      return 1'b1;
    endfunction

    // Compare one result with the oldest expected value
    function void check_result(psvd_pkg::out_res_t got);
      psvd_pkg::out_res_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h overflow %b", got.value, got.overflow);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.value !== exp_res.value || got.overflow !== exp_res.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h overflow %b, got value %h overflow %b",
                   exp_res.value, exp_res.overflow, got.value, got.overflow);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  psvd_pkg::in_req_t  in_req    = '0;
  logic               out_ready = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  psvd_pkg::out_res_t out_res_o;

  decode_scoreboard sb = new;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int taken_cnt     = 0;

  protobuf_scalar_value_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_res_o   (out_res_o)
  );

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Overall time limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Take results, with random stalls and one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) sb.check_result(out_res_o);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic psvd_pkg::in_req_t req(logic [7:0] b, logic [3:0] f);
    psvd_pkg::in_req_t r;
    r.data_byte = b;
    r.func      = f;
    return r;
  endfunction

  // Offer one request, hold it until taken, then idle at random
  task automatic send_byte(psvd_pkg::in_req_t r);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_request(r)) taken_cnt++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_req   <= psvd_pkg::in_req_t'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Send one value of the given type, well-formed unless overflow is set; later bytes carry a random selector
  task automatic send_value(psvd_pkg::func_e f, bit overflow);
    int         n;
    logic [7:0] b;
    case (f)
      psvd_pkg::FUNC_BOOL: begin
        b = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
        send_byte(req(b, f));
      end
      psvd_pkg::FUNC_FIXED32, psvd_pkg::FUNC_FLOAT,
      psvd_pkg::FUNC_FIXED64, psvd_pkg::FUNC_DOUBLE: begin
        n = (f == psvd_pkg::FUNC_FIXED32 || f == psvd_pkg::FUNC_FLOAT) ? 4 : 8;
        for (int i = 0; i < n; i++)
          send_byte(req(8'($urandom), (i == 0) ? 4'(f) : 4'($urandom)));
      end
      default: begin
        n = overflow ? 10 : ($urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(1, 10));
        for (int i = 0; i < n; i++) begin
          b    = 8'($urandom);
          if ($urandom_range(7) == 0) b[6:0] = '0;
          b[7] = overflow || (i < n - 1);
          send_byte(req(b, (i == 0) ? 4'(f) : 4'($urandom)));
        end
      end
    endcase
  endtask

  // Main sequence
  initial begin
    bit held    = 1'b0;
    bit drained = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: varint types, bool, fixed32, dropped selector, selector change, overflow
    send_byte(req(8'h7F, psvd_pkg::FUNC_INT32));
    send_byte(req(8'h00, psvd_pkg::FUNC_INT64));
    send_byte(req(8'hFF, psvd_pkg::FUNC_UINT32));
    send_byte(req(8'h01, psvd_pkg::FUNC_DOUBLE));
    send_byte(req(8'h7F, psvd_pkg::FUNC_UINT64));
    send_byte(req(8'h03, psvd_pkg::FUNC_SINT32));
    send_byte(req(8'h01, psvd_pkg::FUNC_SINT64));
    send_byte(req(8'h05, psvd_pkg::FUNC_ENUM));
    send_byte(req(8'h00, psvd_pkg::FUNC_BOOL));
    send_byte(req(8'h80, psvd_pkg::FUNC_BOOL));
    send_byte(req(8'hFF, FuncUnknown));
    for (int i = 0; i < 4; i++) send_byte(req(8'hFF, psvd_pkg::FUNC_FIXED32));
    for (int i = 0; i < 10; i++) send_byte(req(8'hFF, psvd_pkg::FUNC_INT32));

    // random: mostly well-formed values, some stray bytes
    taken_cnt = 0;
    while (taken_cnt < RandomBytes) begin
      case ((taken_cnt / 250) % 6)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 69; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 69; end
        3:       begin send_idle_pct = 16; stall_pct = 16; end
        default: begin
          send_idle_pct = ($urandom_range(1) == 0) ? 0 : 69;
          stall_pct     = ($urandom_range(1) == 0) ? 0 : 69;
        end
      endcase
      // hold the receiver off while requests keep coming
      if (!held && taken_cnt >= 150) begin
        held = 1'b1;
        hold_seq++;
      end
      // pause the sender until all results are in
      if (!drained && taken_cnt >= 800) begin
        drained  = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      if ($urandom_range(99) < 10)
        send_byte(req(8'($urandom), 4'($urandom)));
      else
        send_value(psvd_pkg::func_e'(4'($urandom_range(11))), $urandom_range(15) == 0);
    end

    // drain and finish
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/psvd_pkg.sv
design/psvd_core.sv
design/psvd_out_buf.sv
design/protobuf_scalar_value_decoder.sv
bench/tb.sv
